/* rtl/core/ure_pkg.sv */
`default_nettype none

package ure_pkg;

  localparam int COUNT_BITS = 17;
  localparam int TRIG_BITS  = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 17;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TRIGGER_TICKS = 3'd0,
    REG_WAIT_TIMEOUT  = 3'd1,
    REG_WIDTH_TIMEOUT = 3'd2,
    REG_MAX_VALID     = 3'd3,
    REG_HOLDOFF_TICKS = 3'd4
  } ure_reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NORESP  = 2'd1,
    ST_TOOLONG = 2'd2,
    ST_RANGE   = 2'd3
  } ure_status_t;

  typedef struct packed {
    logic [TRIG_BITS-1:0]  trigger_ticks;
    logic [COUNT_BITS-1:0] wait_timeout;
    logic [COUNT_BITS-1:0] width_timeout;
    logic [COUNT_BITS-1:0] max_valid;
    logic [COUNT_BITS-1:0] holdoff_ticks;
  } ure_cfg_t;

  typedef struct packed {
    logic                  trigger_out;
    logic                  busy_res;
    logic                  done_res;
    logic [COUNT_BITS-1:0] echo_ticks;
    ure_status_t           status;
  } ure_res_t;

endpackage

`default_nettype wire

/* rtl/core/ure_cfg_regs.sv */
`default_nettype none

module ure_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ure_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [ure_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output ure_pkg::ure_cfg_t                      cfg
);
  import ure_pkg::*;

  ure_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks <= TRIG_BITS'(10);
      cfg_r.wait_timeout  <= COUNT_BITS'(100000);
      cfg_r.width_timeout <= COUNT_BITS'(100000);
      cfg_r.max_valid     <= COUNT_BITS'(25000);
      cfg_r.holdoff_ticks <= COUNT_BITS'(60000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_TICKS: cfg_r.trigger_ticks <= cfg_wdata[TRIG_BITS-1:0];
        REG_WAIT_TIMEOUT:  cfg_r.wait_timeout  <= cfg_wdata[COUNT_BITS-1:0];
        REG_WIDTH_TIMEOUT: cfg_r.width_timeout <= cfg_wdata[COUNT_BITS-1:0];
        REG_MAX_VALID:     cfg_r.max_valid     <= cfg_wdata[COUNT_BITS-1:0];
        REG_HOLDOFF_TICKS: cfg_r.holdoff_ticks <= cfg_wdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/ure_seq.sv */
`default_nettype none

module ure_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              start_req,
  input  wire logic              echo_level,
  input  wire ure_pkg::ure_cfg_t cfg,
  output ure_pkg::ure_res_t      res
);
  import ure_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TRIG  = 3'd1,
    PH_WAIT  = 3'd2,
    PH_WIDTH = 3'd3,
    PH_HOLD  = 3'd4
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] base, bumped;
  logic [COUNT_BITS-1:0] trig_lim;
  phase_t                fin_phase;

  assign trig_lim  = COUNT_BITS'(cfg.trigger_ticks);
  assign fin_phase = (cfg.holdoff_ticks == '0) ? PH_IDLE : PH_HOLD;

  // counter base: fresh start and echo rise both count from zero
  always_comb begin
    base = cnt_r;
    if (phase_r == PH_IDLE) base = '0;
    if (phase_r == PH_WAIT && echo_level) base = '0;
  end

  assign bumped = (base != COUNT_MAX) ? base + COUNT_BITS'(1) : COUNT_MAX;

  always_comb begin
    phase_nxt       = phase_r;
    cnt_nxt         = cnt_r;
    res.trigger_out = 1'b0;
    res.busy_res    = 1'b1;
    res.done_res    = 1'b0;
    res.echo_ticks  = '0;
    res.status      = ST_OK;
    case (phase_r)
      PH_TRIG: begin
        res.trigger_out = 1'b1;
        if (bumped >= trig_lim) begin
          phase_nxt = PH_WAIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = bumped;
        end
      end
      PH_WAIT, PH_WIDTH: begin
        if (echo_level) begin
          if (bumped > cfg.width_timeout || bumped == COUNT_MAX) begin
            res.done_res = 1'b1;
            res.status   = ST_TOOLONG;
            phase_nxt    = fin_phase;
            cnt_nxt      = '0;
          end else begin
            phase_nxt = PH_WIDTH;
            cnt_nxt   = bumped;
          end
        end else if (phase_r == PH_WIDTH) begin
          res.done_res   = 1'b1;
          res.echo_ticks = cnt_r;
          res.status     = (cnt_r >= cfg.max_valid) ? ST_RANGE : ST_OK;
          phase_nxt      = fin_phase;
          cnt_nxt        = '0;
        end else if (bumped > cfg.wait_timeout || bumped == COUNT_MAX) begin
          res.done_res = 1'b1;
          res.status   = ST_NORESP;
          phase_nxt    = fin_phase;
          cnt_nxt      = '0;
        end else begin
          cnt_nxt = bumped;
        end
      end
      PH_HOLD: begin
        if (bumped >= cfg.holdoff_ticks) begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = bumped;
        end
      end
      default: begin
        // idle: a start is already the first trigger tick
        if (!start_req) begin
          res.busy_res = 1'b0;
          phase_nxt    = PH_IDLE;
        end else begin
          res.trigger_out = 1'b1;
          if (bumped >= trig_lim) begin
            phase_nxt = PH_WAIT;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = PH_TRIG;
            cnt_nxt   = bumped;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ultrasonic_echo_ranging.sv */
// input word register, then result word register, which drives the result ports
// throughput: one word per cycle, sustained, while out_stall stays low
// the phase and tick counter update once per word in a single registered pass
// reset (rst_n low, synchronous): idle phase, count zero, both stages empty,
// registers back to 10, 100000, 100000, 25000 and 60000
`default_nettype none

module ultrasonic_echo_ranging (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ure_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [ure_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_start_req,
  input  wire logic                              in_echo_level,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_trigger_out,
  output logic                                   out_busy_res,
  output logic                                   out_done_res,
  output logic [ure_pkg::COUNT_BITS-1:0]         out_echo_ticks,
  output logic [1:0]                             out_status
);
  import ure_pkg::*;

  ure_cfg_t cfg;
  ure_res_t res;
  ure_res_t res_r;
  logic     s1_valid_r;
  logic     s1_start_r;
  logic     s1_echo_r;
  logic     out_valid_r;
  logic     blocked;
  logic     adv;

  assign blocked  = out_valid_r && out_stall;
  assign adv      = s1_valid_r && !blocked;
  assign in_stall = s1_valid_r && blocked;

  ure_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ure_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .start_req  (s1_start_r),
    .echo_level (s1_echo_r),
    .cfg        (cfg),
    .res        (res)
  );

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_start_r <= in_start_req;
      s1_echo_r  <= in_echo_level;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_trigger_out = res_r.trigger_out;
  assign out_busy_res    = res_r.busy_res;
  assign out_done_res    = res_r.done_res;
  assign out_echo_ticks  = res_r.echo_ticks;
  assign out_status      = res_r.status;

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;
  import ure_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 400;
  localparam int MIX_ITEMS = 40;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TRIGGER = 3'd1,
    PH_LISTEN  = 3'd2,
    PH_PULSE   = 3'd3,
    PH_HOLDOFF = 3'd4
  } seq_phase_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic in_start_req;
  logic in_echo_level;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_trigger_out;
  logic out_busy_res;
  logic out_done_res;
  logic [COUNT_BITS-1:0] out_echo_ticks;
  logic [1:0] out_status;

  ure_cfg_t cfg_now;
  seq_phase_t seq_phase;
  logic [COUNT_BITS-1:0] seq_count;
  ure_res_t echo_expect_q[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_start = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int items_sent = 0;
  int err_count = 0;
  int cycle_count = 0;

  ultrasonic_echo_ranging DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_start_req(in_start_req),
    .in_echo_level(in_echo_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_trigger_out(out_trigger_out),
    .out_busy_res(out_busy_res),
    .out_done_res(out_done_res),
    .out_echo_ticks(out_echo_ticks),
    .out_status(out_status)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_start != hold_ack) begin
      hold_ack = hold_start;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic bit timed_out(input logic [COUNT_BITS-1:0] c,
                                   input logic [COUNT_BITS-1:0] limit);
    return (c > limit) || (c == COUNT_MAX);
  endfunction

  function automatic void end_measure(inout ure_res_t r, input logic [COUNT_BITS-1:0] ticks,
                                      input ure_status_t st);
    r.done_res = 1'b1;
    r.echo_ticks = ticks;
    r.status = st;
    seq_phase = (cfg_now.holdoff_ticks == '0) ? PH_IDLE : PH_HOLDOFF;
    seq_count = '0;
  endfunction

  function automatic void pulse_tick(input bit echo, inout ure_res_t r);
    if (echo) begin
      seq_count = count_up(seq_count);
      if (timed_out(seq_count, cfg_now.width_timeout)) end_measure(r, '0, ST_TOOLONG);
    end else begin
      end_measure(r, seq_count, (seq_count >= cfg_now.max_valid) ? ST_RANGE : ST_OK);
    end
  endfunction

  function automatic ure_res_t range_tick(input bit start, input bit echo);
    ure_res_t r;
    r = '0;
    r.busy_res = 1'b1;
    if (seq_phase == PH_IDLE) begin
      if (!start) begin
        r.busy_res = 1'b0;
        return r;
      end
      seq_phase = PH_TRIGGER;
      seq_count = '0;
    end
    case (seq_phase)
      PH_TRIGGER: begin
        r.trigger_out = 1'b1;
        seq_count = count_up(seq_count);
        if (seq_count >= cfg_now.trigger_ticks) begin
          seq_phase = PH_LISTEN;
          seq_count = '0;
        end
      end
      PH_LISTEN: begin
        if (echo) begin
          seq_phase = PH_PULSE;
          seq_count = '0;
          pulse_tick(1'b1, r);
        end else begin
          seq_count = count_up(seq_count);
          if (timed_out(seq_count, cfg_now.wait_timeout)) end_measure(r, '0, ST_NORESP);
        end
      end
      PH_PULSE: pulse_tick(echo, r);
      default: begin
        seq_count = count_up(seq_count);
        if (seq_count >= cfg_now.holdoff_ticks) begin
          seq_phase = PH_IDLE;
          seq_count = '0;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    ure_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (echo_expect_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result word at cycle %0d", cycle_count);
      end else begin
        want = echo_expect_q.pop_front();
        if (out_trigger_out !== want.trigger_out || out_busy_res !== want.busy_res ||
            out_done_res !== want.done_res || out_echo_ticks !== want.echo_ticks ||
            out_status !== want.status) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch cycle %0d want %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                     cycle_count, want.trigger_out, want.busy_res, want.done_res,
                     want.echo_ticks, want.status, out_trigger_out, out_busy_res,
                     out_done_res, out_echo_ticks, out_status);
        end
      end
    end
  end

  task automatic send_tick(input bit start, input bit echo);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      in_start_req <= 1'($urandom);
      in_echo_level <= 1'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= start;
    in_echo_level <= echo;
    do @(posedge clk); while (in_stall);
    echo_expect_q.push_back(range_tick(start, echo));
    items_sent++;
  endtask

  task automatic drain();
    if (echo_expect_q.size() != 0) begin
      in_valid <= 1'b0;
      while (echo_expect_q.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_TRIGGER_TICKS: cfg_now.trigger_ticks = data[TRIG_BITS-1:0];
      REG_WAIT_TIMEOUT:  cfg_now.wait_timeout = data;
      REG_WIDTH_TIMEOUT: cfg_now.width_timeout = data;
      REG_MAX_VALID:     cfg_now.max_valid = data;
      REG_HOLDOFF_TICKS: cfg_now.holdoff_ticks = data;
      default: ;
    endcase
  endtask

  // upper bits of the trigger word are junk and must be dropped
  task automatic set_config(input int trig, input int wait_to, input int width_to,
                            input int max_ok, input int hold);
    logic [31:0] noise;
    noise = $urandom;
    write_reg(REG_TRIGGER_TICKS, {noise[CFG_DATA_BITS-TRIG_BITS-1:0], 8'(trig)});
    write_reg(REG_WAIT_TIMEOUT, 17'(wait_to));
    write_reg(REG_WIDTH_TIMEOUT, 17'(width_to));
    write_reg(REG_MAX_VALID, 17'(max_ok));
    write_reg(REG_HOLDOFF_TICKS, 17'(hold));
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (seq_phase != PH_IDLE) send_tick(1'b0, 1'($urandom));
  endtask

  task automatic run_measurement();
    int wait_len;
    int width_len;
    int n;
    wait_len = $urandom_range(0, cfg_now.wait_timeout + 1);
    width_len = $urandom_range(0, cfg_now.width_timeout + 2);
    if ($urandom_range(99) < 15) repeat ($urandom_range(1, 4)) send_tick(1'($urandom), 1'($urandom));
    while (seq_phase != PH_IDLE) send_tick(1'($urandom), 1'($urandom));
    send_tick(1'b1, 1'($urandom));
    while (seq_phase == PH_TRIGGER) send_tick(1'($urandom), 1'($urandom));
    n = 0;
    while (seq_phase == PH_LISTEN && n < wait_len) begin
      send_tick(1'($urandom), 1'b0);
      n++;
    end
    n = 0;
    while ((seq_phase == PH_LISTEN || seq_phase == PH_PULSE) && n < width_len) begin
      send_tick(1'($urandom), 1'b1);
      n++;
    end
    if (seq_phase == PH_PULSE) send_tick(1'($urandom), 1'b0);
  endtask

  task automatic test_reset_defaults();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    while (seq_phase == PH_TRIGGER) send_tick(1'b0, 1'($urandom));
    repeat (2) send_tick(1'b0, 1'b0);
    repeat (3) send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    drain();
    set_config(10, 100000, 100000, 25000, 0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    drain();
  endtask

  task automatic test_corner_cases();
    int idx;
    set_config(0, 3, 4, 3, 0);
    settle();
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    repeat (4) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    repeat (5) send_tick(1'b0, 1'b1);
    drain();
    set_config(1, 0, 0, 0, 1);
    settle();
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    drain();
    set_config(1, 2, 5, 0, 1);
    settle();
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    drain();
    // writes to unused indexes must leave every register alone
    for (idx = REG_HOLDOFF_TICKS + 1; idx < (1 << CFG_IDX_BITS); idx++)
      write_reg(CFG_IDX_BITS'(idx), CFG_DATA_BITS'($urandom));
    cfg_we <= 1'b0;
    settle();
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    drain();
  endtask

  task automatic test_long_trigger();
    set_config(255, 5, 131071, 131071, 0);
    settle();
    send_tick(1'b1, 1'b0);
    while (seq_phase == PH_TRIGGER) send_tick(1'($urandom), 1'($urandom));
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    int stop_at;
    drain();
    gap_pct = 0;
    stall_pct = 0;
    set_config(2, 8, 10, 6, 2);
    hold_start++;
    stop_at = items_sent + 60;
    while (items_sent < stop_at) run_measurement();
    drain();
  endtask

  task automatic test_random_mix(input int gap, input int stall, input int n_items);
    int stop_at;
    drain();
    gap_pct = gap;
    stall_pct = stall;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      drain();
      set_config(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 5), $urandom_range(12),
                 $urandom_range(15), $urandom_range(16), $urandom_range(6));
      repeat (2) run_measurement();
    end
    drain();
  endtask

  initial begin
    in_valid <= 1'b0;
    in_start_req <= 1'b0;
    in_echo_level <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_TRIGGER_TICKS;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    cfg_now.trigger_ticks = 8'd10;
    cfg_now.wait_timeout = 17'd100000;
    cfg_now.width_timeout = 17'd100000;
    cfg_now.max_valid = 17'd25000;
    cfg_now.holdoff_ticks = 17'd60000;
    seq_phase = PH_IDLE;
    seq_count = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct = 25;
    stall_pct = 25;
    test_reset_defaults();
    test_corner_cases();
    test_long_trigger();
    test_backpressure();
    test_random_mix(0, 0, MIX_ITEMS);
    test_random_mix(64, 0, MIX_ITEMS);
    test_random_mix(0, 64, MIX_ITEMS);
    test_random_mix(37, 37, MIX_ITEMS);
    drain();
    repeat (8) @(posedge clk);
    if (err_count == 0 && echo_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
